### sv/tsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tile span allocator package
// Shared sizes, field widths, operation codes and payload structures of the
// tile span allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

   // Store geometry.
   localparam int TOTAL_TILES         = 2048;
   localparam int TILES_PER_BANK      = 512;
   localparam int TILES_PER_MAP_BLOCK = 64;
   localparam int SEARCH_BANKS        = 2;
   localparam int NUM_LAYERS          = 4;

   // The used bits are kept in memory rows of WORD_BITS tiles.
   localparam int WORD_BITS = 32;
   localparam int ROWS      = TOTAL_TILES / WORD_BITS;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int TILE_W    = $clog2(TOTAL_TILES) + 1;
   localparam int CALC_W    = TILE_W + 2;

   // Field widths.
   localparam int FUNC_W      = 3;
   localparam int LAYER_W     = 2;
   localparam int RUN_W       = 11;
   localparam int MAP_BLOCK_W = 5;
   localparam int MAP_SIZE_W  = 2;
   localparam int GRANT_W     = 10;
   localparam int BANK_W      = 2;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(NUM_LAYERS) + 2;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MAP     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

   // Status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef logic [BANK_W-1:0] bank_type;
   typedef bank_type [NUM_LAYERS-1:0] bank_table_type;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [LAYER_W-1:0]     layer;
      logic [RUN_W-1:0]       run_start;
      logic [RUN_W-1:0]       run_length;
      logic [MAP_BLOCK_W-1:0] map_block;
      logic [MAP_SIZE_W-1:0]  map_size;
   } req_type;

   typedef struct packed {
      logic [GRANT_W-1:0] granted_start;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ROW_W-1:0]     wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [ROW_W-1:0]     rd_addr;
   } ram_req_type;

   // Number of map blocks reserved for a map size code.
   function automatic logic [2:0] map_block_count(input logic [MAP_SIZE_W-1:0] size);
      logic [2:0] n;
      case (size)
         2'd0: begin
            n = 3'd1;
         end
         2'd1, 2'd2: begin
            n = 3'd2;
         end
         default: begin
            n = 3'd4;
         end
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

### sv/tsa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/tsa_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tile span allocator registers
// Register port holding the tile bank of each background layer.
// ----------------------------------------------------------------------------
module tsa_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [tsa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [tsa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [tsa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output tsa_pkg::bank_table_type              banks
);
   import tsa_pkg::*;

   localparam int IDX_W = $clog2(NUM_LAYERS);

   bank_table_type   banks_ff;
   bank_table_type   banks_in;
   logic [IDX_W-1:0] reg_idx;
   logic             wr_strobe;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel & penable & pwrite;

   always_comb begin
      banks_in = banks_ff;
      if (wr_strobe) begin
         banks_in[reg_idx] = pwdata[BANK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff <= '0;
      end else begin
         banks_ff <= banks_in;
      end
   end

   assign prdata = CSR_DATA_W'(banks_ff[reg_idx]);
   assign banks  = banks_ff;

endmodule
`default_nettype wire

### sv/tsa_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tile span allocator sequencer
// Walks the used-bit memory one row at a time: first-fit search, range check
// and read-modify-write marking share one row datapath.
// ----------------------------------------------------------------------------
module tsa_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire tsa_pkg::req_type               req,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output tsa_pkg::rsp_type                    rsp,
   input  wire tsa_pkg::bank_table_type        banks,
   output tsa_pkg::ram_req_type                ram_req,
   input  wire logic [tsa_pkg::WORD_BITS-1:0]  ram_rd_data
);
   import tsa_pkg::*;

   localparam logic [WORD_BITS-1:0] ONES = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH,
      S_CHK_RD,
      S_CHK,
      S_MARK,
      S_MARK_WR,
      S_DONE
   } state_type;

   // Count of zero bits below the lowest set bit, by halving steps.
   function automatic logic [BIT_W-1:0] low_zeros(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] v;
      logic [BIT_W-1:0]     n;
      v = x;
      n = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         if ((v & ((WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1))) == '0) begin
            n[k] = 1'b1;
            v    = v >> (1 << k);
         end
      end
      return n;
   endfunction

   function automatic logic [TILE_W-1:0] clip_tiles(input logic [CALC_W-1:0] v);
      logic [TILE_W-1:0] r;
      if (v > CALC_W'(TOTAL_TILES)) begin
         r = TILE_W'(TOTAL_TILES);
      end else begin
         r = v[TILE_W-1:0];
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [TILE_W-1:0]    pos_ff, pos_in;
   logic [TILE_W-1:0]    lo_ff, lo_in;
   logic [TILE_W-1:0]    hi_ff, hi_in;
   logic [TILE_W-1:0]    base_ff, base_in;
   logic [TILE_W-1:0]    lim_ff, lim_in;
   logic [TILE_W-1:0]    run_start_ff, run_start_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic [RUN_W-1:0]     need_ff, need_in;
   logic [RUN_W-1:0]     len_ff, len_in;
   logic                 set_ff, set_in;
   logic [GRANT_W-1:0]   granted_ff, granted_in;
   logic                 status_ff, status_in;
   logic [ROWS-1:0]      row_valid_ff, row_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Row datapath.
   logic [ROW_W-1:0]     row;
   logic [BIT_W-1:0]     bitp;
   logic [WORD_BITS-1:0] word;
   logic [TILE_W-1:0]    next_row_pos;
   logic [BIT_W-1:0]     lo_cut;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] shifted;
   logic                 has_used;
   logic [BIT_W-1:0]     tz;
   logic [BIT_W:0]       gap;
   logic [RUN_W:0]       run_total;
   logic                 found;
   logic [TILE_W-1:0]    after_used;

   // Item decode.
   logic [CALC_W-1:0]    base_calc;
   logic [CALC_W-1:0]    lim_calc;
   logic [CALC_W-1:0]    first_calc;
   logic [CALC_W-1:0]    end_calc;
   logic [CALC_W-1:0]    map_first;
   logic [CALC_W-1:0]    map_end;

   assign row          = pos_ff[BIT_W +: ROW_W];
   assign bitp         = pos_ff[BIT_W-1:0];
   assign word         = row_valid_ff[row] ? ram_rd_data : '0;
   assign next_row_pos = {pos_ff[TILE_W-1:BIT_W], BIT_W'(0)} + TILE_W'(WORD_BITS);

   assign lo_cut = (lo_ff[TILE_W-1:BIT_W] == pos_ff[TILE_W-1:BIT_W]) ? lo_ff[BIT_W-1:0] : '0;
   assign mask   = (ONES << lo_cut)
                 & ((hi_ff[TILE_W-1:BIT_W] == pos_ff[TILE_W-1:BIT_W])
                    ? ~(ONES << hi_ff[BIT_W-1:0]) : ONES);

   // Free tiles from the current bit up to the next used one or the row end.
   assign shifted    = word >> bitp;
   assign has_used   = |shifted;
   assign tz         = low_zeros(shifted);
   assign gap        = has_used ? {1'b0, tz}
                                : ((BIT_W + 1)'(WORD_BITS) - (BIT_W + 1)'(bitp));
   assign run_total  = (RUN_W + 1)'(run_ff) + (RUN_W + 1)'(gap);
   assign found      = run_total >= (RUN_W + 1)'(need_ff);
   assign after_used = pos_ff + TILE_W'(tz) + TILE_W'(1);

   assign base_calc  = CALC_W'(banks[req.layer]) * CALC_W'(TILES_PER_BANK);
   assign lim_calc   = base_calc + CALC_W'(SEARCH_BANKS * TILES_PER_BANK);
   assign first_calc = base_calc + CALC_W'(req.run_start);
   assign end_calc   = first_calc + CALC_W'(req.run_length);
   assign map_first  = CALC_W'(req.map_block) * CALC_W'(TILES_PER_MAP_BLOCK);
   assign map_end    = map_first
                     + CALC_W'(map_block_count(req.map_size)) * CALC_W'(TILES_PER_MAP_BLOCK);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      base_in      = base_ff;
      lim_in       = lim_ff;
      run_start_in = run_start_ff;
      run_in       = run_ff;
      need_in      = need_ff;
      len_in       = len_ff;
      set_in       = set_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      ram_req      = '0;
      ram_req.rd_addr = row;
      ram_req.wr_addr = row;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               granted_in = '0;
               status_in  = STATUS_OK;
               state_in   = S_DONE;
               case (req.func)
                  FUNC_ALLOC: begin
                     if (base_calc < CALC_W'(TOTAL_TILES)) begin
                        base_in      = base_calc[TILE_W-1:0];
                        lim_in       = clip_tiles(lim_calc);
                        pos_in       = base_calc[TILE_W-1:0];
                        run_start_in = base_calc[TILE_W-1:0];
                        run_in       = '0;
                        len_in       = req.run_length;
                        // A zero-length request looks for one free tile.
                        need_in      = (req.run_length == '0) ? RUN_W'(1) : req.run_length;
                        state_in     = S_SRCH_RD;
                     end else begin
                        status_in = STATUS_FAIL;
                     end
                  end
                  FUNC_FREE: begin
                     lo_in  = clip_tiles(first_calc);
                     hi_in  = clip_tiles(end_calc);
                     pos_in = clip_tiles(first_calc);
                     set_in = 1'b0;
                     if (clip_tiles(first_calc) < clip_tiles(end_calc)) begin
                        state_in = S_MARK;
                     end
                  end
                  FUNC_RESERVE: begin
                     lo_in  = first_calc[TILE_W-1:0];
                     hi_in  = end_calc[TILE_W-1:0];
                     pos_in = first_calc[TILE_W-1:0];
                     set_in = 1'b1;
                     if (end_calc > CALC_W'(TOTAL_TILES)) begin
                        status_in = STATUS_FAIL;
                     end else if (req.run_length != '0) begin
                        state_in = S_CHK_RD;
                     end
                  end
                  FUNC_MAP: begin
                     lo_in  = clip_tiles(map_first);
                     hi_in  = clip_tiles(map_end);
                     pos_in = clip_tiles(map_first);
                     set_in = 1'b1;
                     if (clip_tiles(map_first) < clip_tiles(map_end)) begin
                        state_in = S_MARK;
                     end
                  end
                  FUNC_CLEAR: begin
                     row_valid_in = '0;
                  end
                  default: begin
                     status_in = STATUS_FAIL;
                  end
               endcase
            end
         end

         S_SRCH_RD: begin
            ram_req.rd_en = 1'b1;
            state_in      = S_SRCH;
         end

         S_SRCH: begin
            if (found) begin
               granted_in = GRANT_W'(run_start_ff - base_ff);
               lo_in      = run_start_ff;
               hi_in      = run_start_ff + TILE_W'(len_ff);
               pos_in     = run_start_ff;
               set_in     = 1'b1;
               state_in   = (len_ff == '0) ? S_DONE : S_MARK;
            end else if (has_used) begin
               run_in       = '0;
               run_start_in = after_used;
               pos_in       = after_used;
               if (after_used[BIT_W-1:0] == '0) begin
                  if (after_used >= lim_ff) begin
                     status_in = STATUS_FAIL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
            end else begin
               run_in = run_total[RUN_W-1:0];
               pos_in = next_row_pos;
               if (next_row_pos >= lim_ff) begin
                  status_in = STATUS_FAIL;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end

         S_CHK_RD: begin
            ram_req.rd_en = 1'b1;
            state_in      = S_CHK;
         end

         S_CHK: begin
            if ((word & mask) != '0) begin
               status_in = STATUS_FAIL;
               state_in  = S_DONE;
            end else if (next_row_pos >= hi_ff) begin
               pos_in   = lo_ff;
               state_in = S_MARK;
            end else begin
               pos_in   = next_row_pos;
               state_in = S_CHK_RD;
            end
         end

         S_MARK: begin
            if (mask == ONES) begin
               // Whole row covered: write without reading it first.
               ram_req.wr_en     = 1'b1;
               ram_req.wr_data   = set_ff ? ONES : '0;
               row_valid_in[row] = 1'b1;
               pos_in            = next_row_pos;
               if (next_row_pos >= hi_ff) begin
                  state_in = S_DONE;
               end
            end else begin
               ram_req.rd_en = 1'b1;
               state_in      = S_MARK_WR;
            end
         end

         S_MARK_WR: begin
            ram_req.wr_en     = 1'b1;
            ram_req.wr_data   = set_ff ? (word | mask) : (word & ~mask);
            row_valid_in[row] = 1'b1;
            pos_in            = next_row_pos;
            state_in          = (next_row_pos >= hi_ff) ? S_DONE : S_MARK;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.granted_start = (status_ff == STATUS_OK) ? granted_ff : '0;
               rsp_in.status        = status_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
      pos_ff       <= pos_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      base_ff      <= base_in;
      lim_ff       <= lim_in;
      run_start_ff <= run_start_in;
      run_ff       <= run_in;
      need_ff      <= need_in;
      len_ff       <= len_in;
      set_ff       <= set_in;
      granted_ff   <= granted_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

### sv/tile_span_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tile span allocator
// Used-bit bookkeeping for background tiles with first-fit run allocation.
// ----------------------------------------------------------------------------
// The request channel (req_*) carries one word per operation: allocate, free,
// reserve-at, reserve map blocks or clear-all. The response channel (rsp_*)
// returns exactly one word per request, in order, with the granted start and
// a status bit. The register port selects the tile bank of each layer. It
// must be written only while no request is in flight; the block does not check.
// One request is worked on at a time; req_ready is high only when idle. The
// used bits sit in a 64-row by 32-bit memory behind a single row datapath,
// so the cost is set by the number of rows touched:
//   allocate   : reads and scans each row, scanning a row again after each
//                used tile that does not end the row, then marking.
//   marking    : writes fully covered rows, reads then writes partial ones.
//   reserve-at : reads and checks each row, then marking.
//   clear-all and any failing range check: straight to the response.
// The response is registered in the done state. Reset empties the store
// at once through per-row valid bits and sets every bank to zero. A stalled
// response is held in its output register; the next request is still taken
// and its response waits until the held word leaves.
module tile_span_allocator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [tsa_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [tsa_pkg::LAYER_W-1:0]      req_layer,
   input  wire logic [tsa_pkg::RUN_W-1:0]        req_run_start,
   input  wire logic [tsa_pkg::RUN_W-1:0]        req_run_length,
   input  wire logic [tsa_pkg::MAP_BLOCK_W-1:0]  req_map_block,
   input  wire logic [tsa_pkg::MAP_SIZE_W-1:0]   req_map_size,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [tsa_pkg::GRANT_W-1:0]      rsp_granted_start,
   output logic                                  rsp_status,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [tsa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [tsa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [tsa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);
   import tsa_pkg::*;

   req_type              req;
   rsp_type              rsp;
   bank_table_type       banks;
   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] ram_rd_data;

   assign req.func       = req_func;
   assign req.layer      = req_layer;
   assign req.run_start  = req_run_start;
   assign req.run_length = req_run_length;
   assign req.map_block  = req_map_block;
   assign req.map_size   = req_map_size;

   assign rsp_granted_start = rsp.granted_start;
   assign rsp_status        = rsp.status;

   // Bank registers.
   tsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .banks   (banks)
   );

   // Used-bit store, one row of tiles per word.
   tsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer and row datapath.
   tsa_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .banks       (banks),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

### tb/sv/tb_tile_span_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile span allocator testbench
// Self-checking bench. It drives allocate, free, reserve-at, map and clear-all
// words through the request channel under random idling and back-pressure.
// It programs the layer banks over the register port and reads them back. It
// predicts every response with its own model of the tile used-bits.
// ----------------------------------------------------------------------------
module tb_tile_span_allocator_top;
   import tsa_pkg::*;

   // Function codes that the block does not implement. They must come back
   // with a failing status and leave the store alone.
   localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNDEF_MID = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI  = 3'd7;

   // Register map: one bank register per layer, 4 bytes apart.
   localparam int CSR_BANK0_ADDR = 0;
   localparam int CSR_STRIDE     = 4;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 8;
   localparam int QUEUE_DEPTH     = 4;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int END_CYCLES      = 20;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int PHASE_ITEMS     = 146;
   localparam int PRINT_CAP       = 200;
   localparam int MAX_RUN_LEN     = 1024;
   localparam int LIVE_RUNS_MAX   = 64;

   typedef struct {
      rsp_type word;
      int      seq;
   } tile_verdict_type;

   typedef struct {
      int first;
      int count;
   } tile_run_type;

   logic                   clock;
   logic                   reset = 1'b1;

   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [FUNC_W-1:0]      req_func       = '0;
   logic [LAYER_W-1:0]     req_layer      = '0;
   logic [RUN_W-1:0]       req_run_start  = '0;
   logic [RUN_W-1:0]       req_run_length = '0;
   logic [MAP_BLOCK_W-1:0] req_map_block  = '0;
   logic [MAP_SIZE_W-1:0]  req_map_size   = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [GRANT_W-1:0]     rsp_granted_start;
   logic                   rsp_status;

   logic                   psel    = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr   = '0;
   logic [CSR_DATA_W-1:0]  pwdata  = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // Model state: one used bit per tile and the bank of each layer as the
   // block should currently see it.
   logic [TOTAL_TILES-1:0] tile_used   = '0;
   bank_table_type         bank_shadow = '0;

   req_type                pending_reqs[$];
   tile_verdict_type       expected_rsps[$];
   tile_run_type           live_runs[$];
   req_type                offered_word;

   int req_idle_pct    = 14;
   int rsp_stall_pct   = 14;
   int holdoff_trigger = 0;
   int mismatch_count  = 0;
   int words_accepted  = 0;
   int rsps_checked    = 0;
   int grants_ok       = 0;
   int grants_refused  = 0;
   int settings_count  = 0;

   tile_span_allocator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_layer         (req_layer),
      .req_run_start     (req_run_start),
      .req_run_length    (req_run_length),
      .req_map_block     (req_map_block),
      .req_map_size      (req_map_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_start (rsp_granted_start),
      .rsp_status        (rsp_status),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Reporting
   // ------------------------------------------------------------------------

   // Every mismatch is counted. Printing stops after a cap so that a badly
   // broken block does not flood the log.
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Tile store model
   // ------------------------------------------------------------------------

   function automatic int bank_base(input int layer);
      return int'(bank_shadow[layer]) * TILES_PER_BANK;
   endfunction

   // Sets or clears a run of used bits. Anything at or past the end of the
   // store is dropped, which gives the clipping of free and map.
   function automatic void mark_tiles(input int first, input int count, input logic value);
      for (int i = 0; i < count; i++) begin
         if (first + i >= TOTAL_TILES) begin
            break;
         end
         tile_used[first + i] = value;
      end
   endfunction

   // Works out the response word for one request and applies its effect to
   // the model store.
   function automatic rsp_type predict_tiles(input req_type w);
      rsp_type r;
      int      base;
      int      limit;
      int      first;
      int      span;
      int      blocks;
      r.granted_start = '0;
      r.status        = STATUS_OK;
      base            = bank_base(int'(w.layer));
      case (w.func)
         FUNC_ALLOC: begin
            // First fit inside a two-bank window, cut at the end of the store.
            limit = base + SEARCH_BANKS * TILES_PER_BANK;
            if (limit > TOTAL_TILES) begin
               limit = TOTAL_TILES;
            end
            first    = base;
            span     = 0;
            r.status = STATUS_FAIL;
            while (first + span < limit && r.status == STATUS_FAIL) begin
               if (tile_used[first + span]) begin
                  first = first + span + 1;
                  span  = 0;
               end else begin
                  span++;
                  // A zero-length request stops at the first free tile.
                  if (span >= int'(w.run_length)) begin
                     mark_tiles(first, int'(w.run_length), 1'b1);
                     r.granted_start = GRANT_W'(first - base);
                     r.status        = STATUS_OK;
                  end
               end
            end
         end
         FUNC_FREE: begin
            mark_tiles(base + int'(w.run_start), int'(w.run_length), 1'b0);
         end
         FUNC_RESERVE: begin
            first = base + int'(w.run_start);
            if (first + int'(w.run_length) > TOTAL_TILES) begin
               r.status = STATUS_FAIL;
            end else begin
               for (int i = 0; i < int'(w.run_length); i++) begin
                  if (tile_used[first + i]) begin
                     r.status = STATUS_FAIL;
                  end
               end
               if (r.status == STATUS_OK) begin
                  mark_tiles(first, int'(w.run_length), 1'b1);
               end
            end
         end
         FUNC_MAP: begin
            case (w.map_size)
               2'd0: begin
                  blocks = 1;
               end
               2'd1, 2'd2: begin
                  blocks = 2;
               end
               default: begin
                  blocks = 4;
               end
            endcase
            mark_tiles(int'(w.map_block) * TILES_PER_MAP_BLOCK,
                       blocks * TILES_PER_MAP_BLOCK, 1'b1);
         end
         FUNC_CLEAR: begin
            tile_used = '0;
         end
         default: begin
            r.status = STATUS_FAIL;
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // Offers the next pending word, idling at random. A word stays on the
   // port untouched until it is taken. The expected response is worked out
   // at the edge where the word is accepted, so the model sees requests in
   // exactly the order the block does.
   always @(posedge clock) begin : drive_words
      logic    next_valid;
      rsp_type predicted;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_tiles(offered_word);
            expected_rsps.push_back('{word: predicted, seq: words_accepted});
            if (offered_word.func == FUNC_ALLOC) begin
               if (predicted.status == STATUS_OK) begin
                  grants_ok++;
                  // Remember real runs so that later frees can hit them.
                  if (offered_word.run_length != 0 && offered_word.run_length <= MAX_RUN_LEN) begin
                     live_runs.push_back('{
                        first: bank_base(int'(offered_word.layer)) + int'(predicted.granted_start),
                        count: int'(offered_word.run_length)});
                     if (live_runs.size() > LIVE_RUNS_MAX) begin
                        void'(live_runs.pop_front());
                     end
                  end
               end else begin
                  grants_refused++;
               end
            end
            words_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            offered_word   = pending_reqs.pop_front();
            req_func       <= offered_word.func;
            req_layer      <= offered_word.layer;
            req_run_start  <= offered_word.run_start;
            req_run_length <= offered_word.run_length;
            req_map_block  <= offered_word.map_block;
            req_map_size   <= offered_word.map_size;
            next_valid     = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Response receiver and checker
   // ------------------------------------------------------------------------

   // Ready is dropped at random. When the stimulus bumps the trigger, the
   // receiver holds off for a long stretch that it counts itself. That lets
   // the block fill its output register and then refuse new requests.
   always @(posedge clock) begin : pace_responses
      int holdoff_seen;
      int holdoff_left;
      if (holdoff_trigger != holdoff_seen) begin
         holdoff_seen = holdoff_trigger;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Each accepted response word is checked against the oldest prediction.
   always @(posedge clock) begin : check_responses
      tile_verdict_type expect_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("response word with no request waiting (start %0d status %0d)",
                                      rsp_granted_start, rsp_status));
         end else begin
            expect_word = expected_rsps.pop_front();
            if (rsp_granted_start !== expect_word.word.granted_start) begin
               report_mismatch($sformatf("request %0d: granted_start %0d, expected %0d",
                                         expect_word.seq, rsp_granted_start,
                                         expect_word.word.granted_start));
            end
            if (rsp_status !== expect_word.word.status) begin
               report_mismatch($sformatf("request %0d: status %0d, expected %0d",
                                         expect_word.seq, rsp_status, expect_word.word.status));
            end
            rsps_checked++;
         end
      end
   end

   // The run is ended if neither channel moves a word and the register port
   // is quiet for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, expected_rsps.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------

   // A setup phase, then an access phase. pready is waited for even though the
   // block keeps it high. The task returns the read data at the edge
   // that completes the access.
   task automatic csr_access(input int idx, input logic write_en,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= CSR_ADDR_W'(CSR_BANK0_ADDR + CSR_STRIDE * idx);
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      rdata   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes all four layer banks, mirrors them into the model and reads each
   // one back.
   task automatic set_banks(input bank_type b0, input bank_type b1,
                            input bank_type b2, input bank_type b3);
      bank_table_type               table_next;
      logic [CSR_DATA_W-1:0] readback;
      table_next = {b3, b2, b1, b0};
      for (int i = 0; i < NUM_LAYERS; i++) begin
         csr_access(i, 1'b1, CSR_DATA_W'(table_next[i]), readback);
         bank_shadow[i] = table_next[i];
      end
      for (int i = 0; i < NUM_LAYERS; i++) begin
         csr_access(i, 1'b0, '0, readback);
         if (readback !== CSR_DATA_W'(table_next[i])) begin
            report_mismatch($sformatf("bank register %0d reads %0h, expected %0h",
                                      i, readback, table_next[i]));
         end
      end
      settings_count++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic req_type make_word(input logic [FUNC_W-1:0] func, input int layer,
                                         input int start, input int len,
                                         input int block, input int size);
      req_type w;
      w.func       = func;
      w.layer      = LAYER_W'(layer);
      w.run_start  = RUN_W'(start);
      w.run_length = RUN_W'(len);
      w.map_block  = MAP_BLOCK_W'(block);
      w.map_size   = MAP_SIZE_W'(size);
      return w;
   endfunction

   // Mostly short runs, sometimes up to a full window. Now and then the
   // whole 11-bit field is random, which is often longer than any window.
   function automatic int span_length();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel == 0) begin
         return 0;
      end else if (sel <= 6) begin
         return $urandom_range(48, 1);
      end else if (sel <= 8) begin
         return $urandom_range(MAX_RUN_LEN, 49);
      end
      return $urandom_range((1 << RUN_W) - 1);
   endfunction

   // Picks a layer whose bank lies at or below the run. Returns -1 if there
   // is none.
   function automatic int layer_below(input int first);
      int unsigned offset;
      int          k;
      offset = $urandom_range(NUM_LAYERS - 1);
      for (int i = 0; i < NUM_LAYERS; i++) begin
         k = (i + offset) % NUM_LAYERS;
         if (bank_base(k) <= first) begin
            return k;
         end
      end
      return -1;
   endfunction

   // Mostly allocations paired with frees of runs that were really granted.
   // Around them are reserve-at, map and the odd clear-all. A few words are
   // malformed or wholly random. Unused fields always carry junk.
   function automatic req_type random_word();
      req_type      w;
      int unsigned  pick;
      int unsigned  sel;
      int           layer;
      tile_run_type run;
      w.func       = FUNC_ALLOC;
      w.layer      = LAYER_W'($urandom);
      w.run_start  = RUN_W'($urandom);
      w.run_length = RUN_W'($urandom);
      w.map_block  = MAP_BLOCK_W'($urandom);
      w.map_size   = MAP_SIZE_W'($urandom);
      pick         = $urandom_range(99);
      if (pick < 40) begin
         w.func       = FUNC_ALLOC;
         w.run_length = RUN_W'(span_length());
      end else if (pick < 64) begin
         w.func = FUNC_FREE;
         layer  = -1;
         if (live_runs.size() != 0 && $urandom_range(9) < 7) begin
            sel = $urandom_range(live_runs.size() - 1);
            run = live_runs[sel];
            live_runs.delete(sel);
            layer = layer_below(run.first);
         end
         if (layer >= 0) begin
            w.layer      = LAYER_W'(layer);
            w.run_start  = RUN_W'(run.first - bank_base(layer));
            w.run_length = RUN_W'(run.count);
         end else begin
            w.run_length = RUN_W'(span_length());
         end
      end else if (pick < 80) begin
         w.func = FUNC_RESERVE;
         if ($urandom_range(9) < 8) begin
            w.run_start  = RUN_W'($urandom_range(MAX_RUN_LEN - 1));
            w.run_length = RUN_W'($urandom_range(64));
         end
      end else if (pick < 88) begin
         w.func = FUNC_MAP;
      end else if (pick < 90) begin
         w.func = FUNC_CLEAR;
      end else if (pick < 93) begin
         w.func = FUNC_W'($urandom_range(FUNC_UNDEF_HI, FUNC_UNDEF_LO));
      end else begin
         w.func = FUNC_W'($urandom);
      end
      return w;
   endfunction

   // Waits until every queued word has been taken and answered, then lets
   // the block settle before the registers are touched. The queues and the
   // valid are looked at on the falling edge, once the rising edge's updates
   // have all landed.
   task automatic drain_requests();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Keeps a few words queued ahead of the driver, so that the sender always
   // has something to offer while the receiver holds off.
   task automatic run_random_phase(input int items, input logic with_holdoff);
      for (int i = 0; i < items; i++) begin
         while (pending_reqs.size() >= QUEUE_DEPTH) begin
            @(posedge clock);
         end
         if (with_holdoff && i == 40) begin
            holdoff_trigger++;
         end
         pending_reqs.push_back(random_word());
      end
      drain_requests();
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Every bank is different, so each layer searches its
      // own window and layer 3 has a window cut short by the end of the
      // store.
      set_banks(2'd0, 2'd1, 2'd2, 2'd3);
      // A zero-length allocate on an empty store finds tile 0.
      pending_reqs.push_back(make_word(FUNC_ALLOC,   0, 0,    0,    0,  0));
      // A 1024-tile run fills the whole two-bank window of layer 0.
      pending_reqs.push_back(make_word(FUNC_ALLOC,   0, 0,    1024, 0,  0));
      // The window is full now, so both of these fail.
      pending_reqs.push_back(make_word(FUNC_ALLOC,   0, 0,    1,    0,  0));
      pending_reqs.push_back(make_word(FUNC_ALLOC,   0, 0,    0,    0,  0));
      // Layer 1's window overlaps; the first free tile is a bank further on.
      pending_reqs.push_back(make_word(FUNC_ALLOC,   1, 0,    1,    0,  0));
      // Punch a hole and let first fit find it again.
      pending_reqs.push_back(make_word(FUNC_FREE,    0, 100,  50,   0,  0));
      pending_reqs.push_back(make_word(FUNC_ALLOC,   0, 0,    50,   0,  0));
      // A reserve-at that ends exactly at the last tile, then one past it.
      pending_reqs.push_back(make_word(FUNC_RESERVE, 0, 2000, 48,   0,  0));
      pending_reqs.push_back(make_word(FUNC_RESERVE, 3, 511,  2,    0,  0));
      // Zero-length reserve-at and free succeed without touching the store.
      pending_reqs.push_back(make_word(FUNC_RESERVE, 3, 400,  0,    0,  0));
      pending_reqs.push_back(make_word(FUNC_FREE,    0, 0,    0,    0,  0));
      // Frees that run off the end are clipped.
      pending_reqs.push_back(make_word(FUNC_FREE,    3, 2047, 2047, 0,  0));
      pending_reqs.push_back(make_word(FUNC_FREE,    2, 0,    2047, 0,  0));
      // Map reservations of every size code, the last block clipped.
      pending_reqs.push_back(make_word(FUNC_MAP,     0, 0,    0,    31, 3));
      pending_reqs.push_back(make_word(FUNC_MAP,     0, 0,    0,    0,  0));
      pending_reqs.push_back(make_word(FUNC_MAP,     0, 0,    0,    1,  1));
      pending_reqs.push_back(make_word(FUNC_MAP,     0, 0,    0,    4,  2));
      // Runs longer than layer 3's shortened window cannot fit.
      pending_reqs.push_back(make_word(FUNC_ALLOC,   3, 0,    600,  0,  0));
      pending_reqs.push_back(make_word(FUNC_ALLOC,   3, 2047, 2047, 31, 3));
      // Undefined function codes with every field at its top value.
      pending_reqs.push_back(make_word(FUNC_UNDEF_LO,  3, 2047, 2047, 31, 3));
      pending_reqs.push_back(make_word(FUNC_UNDEF_MID, 3, 2047, 2047, 31, 3));
      pending_reqs.push_back(make_word(FUNC_UNDEF_HI,  3, 2047, 2047, 31, 3));
      // Reserve-at onto a used tile is a conflict.
      pending_reqs.push_back(make_word(FUNC_RESERVE, 0, 0,    1,    0,  0));
      // Clear-all, after which layer 3's whole bank is available again.
      pending_reqs.push_back(make_word(FUNC_CLEAR,   0, 0,    0,    0,  0));
      pending_reqs.push_back(make_word(FUNC_ALLOC,   3, 0,    512,  0,  0));
      drain_requests();

      // Random part. Each phase ends with the sender waiting for every
      // response, so the bank registers are only changed while idle.
      set_banks(2'd3, 2'd3, 2'd3, 2'd3);
      run_random_phase(PHASE_ITEMS, 1'b0);

      set_banks(2'd0, 2'd0, 2'd0, 2'd0);
      run_random_phase(PHASE_ITEMS, 1'b1);

      // A phase with no idling on either side.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_banks(bank_type'($urandom), bank_type'($urandom),
                bank_type'($urandom), bank_type'($urandom));
      run_random_phase(PHASE_ITEMS, 1'b0);
      req_idle_pct  = 14;
      rsp_stall_pct = 14;

      for (int p = 0; p < 3; p++) begin
         set_banks(bank_type'($urandom), bank_type'($urandom),
                   bank_type'($urandom), bank_type'($urandom));
         run_random_phase(PHASE_ITEMS, p == 1);
      end

      repeat (END_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
      end

      $display("Checked %0d responses to %0d request words under %0d bank settings.",
               rsps_checked, words_accepted, settings_count);
      $display("Allocations granted: %0d, refused: %0d; mismatches: %0d.",
               grants_ok, grants_refused, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
sv/tsa_pkg.sv
sv/tsa_ram.sv
sv/tsa_csr.sv
sv/tsa_core.sv
sv/tile_span_allocator_top.sv
tb/sv/tb_tile_span_allocator_top.sv
